/* rtl/bfg_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfg_pkg
// shared widths, constants, register codes and table entry, stage and
// result types of the burst timestamp fix and window grouper
// ----------------------------------------------------------------------------
package bfg_pkg;

    localparam int CARD_W   = 5;
    localparam int CHAN_W   = 6;
    localparam int TIME_W   = 63;
    localparam int RANGE_W  = 2;
    localparam int COUNT_W  = 16;
    localparam int WINDOW_W = 32;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = WINDOW_W;

    localparam int NUM_CARDS_DEF         = 32;
    localparam int CHANNELS_PER_CARD_DEF = 64;
    localparam int ASICS_PER_CARD        = 4;
    localparam int CH_PER_ASIC           = 16;

    localparam logic [TIME_W:0]     BURST_STEP   = (TIME_W + 1)'(200);
    localparam logic [WINDOW_W-1:0] WINDOW_RESET = WINDOW_W'(201);
    localparam logic [COUNT_W-1:0]  COUNT_MAX    = '1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BURST_FIX = 1'd1;

    // range codes
    localparam logic [RANGE_W-1:0] RANGE_LOW  = 2'd0;
    localparam logic [RANGE_W-1:0] RANGE_HIGH = 2'd1;

    typedef struct packed {
        logic [TIME_W-1:0]  prev_time;
        logic [TIME_W-1:0]  prev_ext_time;
        logic [TIME_W-1:0]  first_time;
        logic [TIME_W-1:0]  first_ext_time;
        logic [COUNT_W-1:0] burst_count;
    } t_entry;

    typedef struct packed {
        logic [TIME_W-1:0]  raw_time;
        logic [TIME_W-1:0]  raw_ext_time;
        logic [RANGE_W-1:0] range_kind;
        logic               strip_valid;
        logic               tbl_en;
    } t_s1;

    typedef struct packed {
        logic [TIME_W-1:0] fixed_time;
        logic [TIME_W-1:0] fixed_ext_time;
        logic              in_burst;
        logic              new_event;
        logic              closed_was_high;
        logic              hit_kept;
    } t_res;

endpackage

/* rtl/bfg_hit_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfg_hit_if
// valid/ready channel carrying one adc hit per beat
// ----------------------------------------------------------------------------
interface bfg_hit_if import bfg_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [CARD_W-1:0]  fee_number;
    logic [CHAN_W-1:0]  fee_channel;
    logic [TIME_W-1:0]  raw_time;
    logic [TIME_W-1:0]  raw_ext_time;
    logic [RANGE_W-1:0] range_kind;
    logic               strip_valid;

    modport source (output valid, fee_number, fee_channel, raw_time, raw_ext_time,
                    range_kind, strip_valid, input ready);
    modport sink   (input valid, fee_number, fee_channel, raw_time, raw_ext_time,
                    range_kind, strip_valid, output ready);
endinterface

/* rtl/bfg_res_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfg_res_if
// valid/ready channel carrying one corrected hit result per beat
// ----------------------------------------------------------------------------
interface bfg_res_if import bfg_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [TIME_W-1:0] fixed_time;
    logic [TIME_W-1:0] fixed_ext_time;
    logic              in_burst;
    logic              new_event;
    logic              closed_was_high;
    logic              hit_kept;

    modport source (output valid, fixed_time, fixed_ext_time, in_burst, new_event,
                    closed_was_high, hit_kept, input ready);
    modport sink   (input valid, fixed_time, fixed_ext_time, in_burst, new_event,
                    closed_was_high, hit_kept, output ready);
endinterface

/* rtl/asic_burst_ts_fix_window_grouper.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asic_burst_ts_fix_window_grouper
// per-asic burst timestamp correction and coincidence window grouping
// ----------------------------------------------------------------------------
// Hits enter on i_hit, one per beat; each gives exactly one result beat on
// o_res, in order. The config port (i_cfg_we, i_cfg_addr, i_cfg_data) sets
// the window (index 0) and the burst fix enable (index 1); write it only
// while no hit is in flight.
// An accepted hit is registered in the compute stage, then in the output
// register that drives o_res. Throughput: one hit per cycle while o_res
// does not stall. The per-asic table is one synchronous memory read at
// accept, written back as the hit leaves the compute stage; a same-asic
// hit taken with that write-back reads a bypass register, not the memory.
// Reset clears the per-entry valid bits (no clearing pass),
// loads window 201 and burst fix on, and marks the next hit as the first.
// When o_res stalls, the result holds in the output register; one more hit
// is still accepted into the compute stage, after which i_hit.ready drops
// until the output drains.
// ----------------------------------------------------------------------------
module asic_burst_ts_fix_window_grouper
    import bfg_pkg::*;
#(
    parameter int NUM_CARDS         = NUM_CARDS_DEF,
    parameter int CHANNELS_PER_CARD = CHANNELS_PER_CARD_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    bfg_hit_if.sink               i_hit,
    bfg_res_if.source             o_res
);

    localparam int NUM_ASICS = NUM_CARDS * ASICS_PER_CARD;
    localparam int AW        = (NUM_ASICS > 1) ? $clog2(NUM_ASICS) : 1;

    // configuration
    logic [WINDOW_W-1:0] r_window;
    logic                r_burst_fix;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window    <= WINDOW_RESET;
            r_burst_fix <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                REG_WINDOW:    r_window    <= i_cfg_data;
                REG_BURST_FIX: r_burst_fix <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // pipeline control
    logic    r_s1_valid;
    t_s1     r_s1;
    logic [AW-1:0] r_s1_idx;
    logic    r_out_valid;
    t_res    r_out;
    logic    s1_adv;
    logic    hit_acc;
    logic    s1_wr;

    assign s1_adv      = !r_out_valid || o_res.ready;
    assign i_hit.ready = !r_s1_valid || s1_adv;
    assign hit_acc     = i_hit.valid && i_hit.ready;
    assign s1_wr       = r_s1_valid && s1_adv && r_s1.tbl_en;

    // input decode
    logic          in_tbl_en;
    logic [AW-1:0] in_idx;

    assign in_tbl_en = (i_hit.range_kind == RANGE_LOW || i_hit.range_kind == RANGE_HIGH)
                       && ({1'b0, i_hit.fee_number} < (CARD_W + 1)'(NUM_CARDS))
                       && ({1'b0, i_hit.fee_channel} < (CHAN_W + 1)'(CHANNELS_PER_CARD));
    // card * 4 + channel / 16
    assign in_idx = AW'({i_hit.fee_number, i_hit.fee_channel[CHAN_W-1 -: 2]});

    // asic table memory
    t_entry        mem [NUM_ASICS];
    logic [NUM_ASICS-1:0] r_entry_vld;
    t_entry        r_rd_entry;
    logic          r_rd_valid;
    logic          r_fwd;
    t_entry        r_fwd_entry;
    t_entry        n_entry;

    always_ff @(posedge i_clk) begin
        if (s1_wr) begin
            mem[r_s1_idx] <= n_entry;
        end
        if (hit_acc) begin
            r_rd_entry  <= mem[in_idx];
            r_fwd_entry <= n_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_vld <= '0;
            r_rd_valid  <= 1'b0;
            r_fwd       <= 1'b0;
        end else begin
            if (s1_wr) begin
                r_entry_vld[r_s1_idx] <= 1'b1;
            end
            if (hit_acc) begin
                r_rd_valid <= r_entry_vld[in_idx];
                // entry being written back in this same cycle bypasses the memory
                r_fwd      <= s1_wr && (r_s1_idx == in_idx);
            end
        end
    end

    // stage 1 registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_hit.ready) begin
            r_s1_valid <= i_hit.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (hit_acc) begin
            r_s1.raw_time     <= i_hit.raw_time;
            r_s1.raw_ext_time <= i_hit.raw_ext_time;
            r_s1.range_kind   <= i_hit.range_kind;
            r_s1.strip_valid  <= i_hit.strip_valid;
            r_s1.tbl_en       <= in_tbl_en;
            r_s1_idx          <= in_idx;
        end
    end

    // stage 1 compute
    logic [TIME_W-1:0] r_last;
    logic              r_first_pend;
    logic              r_event_high;
    t_entry            cur;
    logic              burst;
    logic [TIME_W-1:0] last_eff;
    logic [TIME_W:0]   limit;
    logic              newev;
    t_res              n_out;
    logic [TIME_W-1:0] first_t;
    logic [TIME_W-1:0] first_e;

    always_comb begin
        if (r_fwd) begin
            cur = r_fwd_entry;
        end else if (r_rd_valid) begin
            cur = r_rd_entry;
        end else begin
            cur = '0;
        end

        burst   = r_s1.tbl_en && ({1'b0, r_s1.raw_time} == {1'b0, cur.prev_time} + BURST_STEP);
        first_t = (cur.burst_count == '0) ? cur.prev_time : cur.first_time;
        first_e = (cur.burst_count == '0) ? cur.prev_ext_time : cur.first_ext_time;

        n_entry               = cur;
        n_entry.prev_time     = r_s1.raw_time;
        n_entry.prev_ext_time = r_s1.raw_ext_time;
        if (burst) begin
            n_entry.first_time     = first_t;
            n_entry.first_ext_time = first_e;
            if (cur.burst_count != COUNT_MAX) begin
                n_entry.burst_count = cur.burst_count + COUNT_W'(1);
            end
        end else begin
            n_entry.burst_count = '0;
        end

        last_eff = r_first_pend ? r_s1.raw_time : r_last;
        limit    = {1'b0, last_eff} + (TIME_W + 1)'(r_window);
        newev    = {1'b0, r_s1.raw_time} > limit;

        n_out.fixed_time      = (burst && r_burst_fix) ? first_t : r_s1.raw_time;
        n_out.fixed_ext_time  = (burst && r_burst_fix) ? first_e : r_s1.raw_ext_time;
        n_out.in_burst        = burst;
        n_out.new_event       = newev;
        n_out.closed_was_high = newev && r_event_high;
        n_out.hit_kept        = r_s1.strip_valid
                                && (r_s1.range_kind == RANGE_LOW || r_s1.range_kind == RANGE_HIGH);
    end

    // window state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last       <= '0;
            r_first_pend <= 1'b1;
            r_event_high <= 1'b0;
        end else if (r_s1_valid && s1_adv) begin
            r_last       <= r_s1.raw_time;
            r_first_pend <= 1'b0;
            if (r_s1.range_kind == RANGE_HIGH) begin
                r_event_high <= 1'b1;
            end else if (r_s1.range_kind == RANGE_LOW && newev) begin
                r_event_high <= 1'b0;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_valid && s1_adv) begin
            r_out <= n_out;
        end
    end

    assign o_res.valid           = r_out_valid;
    assign o_res.fixed_time      = r_out.fixed_time;
    assign o_res.fixed_ext_time  = r_out.fixed_ext_time;
    assign o_res.in_burst        = r_out.in_burst;
    assign o_res.new_event       = r_out.new_event;
    assign o_res.closed_was_high = r_out.closed_was_high;
    assign o_res.hit_kept        = r_out.hit_kept;

    // assertions
    a_no_accept_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !s1_adv) |-> !hit_acc)
        else $error("hit accepted while compute stage is stalled");

    a_closed_high_needs_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.closed_was_high) |-> r_out.new_event)
        else $error("closed_was_high without new_event");

    a_first_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && s1_adv) |=> !r_first_pend)
        else $error("first hit flag not cleared after a hit");

    a_no_table_raw_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && s1_adv && !r_s1.tbl_en) |=>
        (!r_out.in_burst && r_out.fixed_time == $past(r_s1.raw_time)))
        else $error("hit without table access got a corrected timestamp");

    a_fwd_only_after_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (hit_acc && !s1_wr) |=> !r_fwd)
        else $error("bypass taken without a write-back");

endmodule
